@@ hw/rtl/tcc_pkg.sv @@
// shared types and constants for the transpose tag cache
package tcc_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned LIMIT_W     = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic CMD_LOOKUP  = 1'b0;
  localparam logic CMD_ADD     = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  // one cached descriptor
  typedef struct packed {
    logic [WORD_W-1:0] tag_index;
    logic [WORD_W-1:0] tag_type;
    logic [WORD_W-1:0] tag_count;
  } entry_t;

  // per-cell update control
  typedef struct packed {
    logic cmp_en;      // capture the key compare
    logic load_new;    // store the incoming word
    logic take_left;   // take the word of the cell ahead
    logic take_right;  // take the word of the cell behind
  } cell_ctl_t;

endpackage

@@ hw/rtl/transpose_tag_cache.sv @@
// top level of the transpose tag cache: control, held count and the cell row
// flow: an accepted word is registered, passes the compare cycle and then the select/update cycle,
// which registers its result word; a new word can be taken in the select/update cycle, not in the compare cycle
// the select cycle waits while a finished result is stalled at the output
// reset: synchronous active-low; clears held count, control and limit (64)
// entry contents are not cleared; only positions below the held count are read
module transpose_tag_cache #(
  parameter int unsigned CACHE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_command,
  input  logic [tcc_pkg::WORD_W-1:0]  in_tag_index,
  input  logic [tcc_pkg::WORD_W-1:0]  in_tag_type,
  input  logic [tcc_pkg::WORD_W-1:0]  in_tag_count,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic [tcc_pkg::WORD_W-1:0]  out_found_type,
  output logic [tcc_pkg::WORD_W-1:0]  out_found_count,
  // limit register write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcc_pkg::LIMIT_W-1:0] cfg_cache_limit
);
  import tcc_pkg::*;

  localparam int unsigned IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CACHE_DEPTH + 1);
  // width wide enough for both the limit register and the held count
  localparam int unsigned EXT_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // control state
  logic               cmp_r;      // word in compare cycle
  logic               sel_r;      // word in select/update cycle
  logic               cmp_nxt;
  logic               sel_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   held_r;
  logic [CNT_W-1:0]   held_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;

  // captured request
  logic               cmd_r;
  entry_t             item_r;

  // result payload
  logic               status_r;
  logic [WORD_W-1:0]  type_r;
  logic [WORD_W-1:0]  count_r;

  logic in_accept;
  logic out_blocked;
  logic sel_go;

  // cell row wiring
  entry_t           words [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] match_raw;
  logic [CACHE_DEPTH-1:0] valid_pos;
  logic [CACHE_DEPTH-1:0] match_ok;
  logic [CACHE_DEPTH-1:0] first_hit;
  logic             hit;
  entry_t           hit_word;

  // add slot selection
  logic [EXT_W-1:0] lim_ext;
  logic [EXT_W-1:0] held_ext;
  logic             room;
  logic [CNT_W-1:0] held_dec;
  logic [IDX_W-1:0] slot;
  logic             add_go;
  logic             swap_go;

  // handshake
  assign out_blocked = out_valid_r & out_stall;
  assign in_stall    = cmp_r | (sel_r & out_blocked);
  assign in_accept   = in_valid & ~in_stall;
  assign sel_go      = sel_r & ~out_blocked;
  assign cfg_ready   = 1'b1;

  assign cmp_nxt = in_accept;
  assign sel_nxt = cmp_r | (sel_r & out_blocked);

  // effective limit: clipped to the depth, never below one
  always_comb begin
    lim_ext = EXT_W'(limit_r);
    if (lim_ext > EXT_W'(CACHE_DEPTH)) begin
      lim_ext = EXT_W'(CACHE_DEPTH);
    end else if (lim_ext == '0) begin
      lim_ext = EXT_W'(1);
    end
  end

  assign held_ext = EXT_W'(held_r);
  assign room     = held_ext < lim_ext;
  assign held_dec = held_r - CNT_W'(1);
  // when full the tail entry is overwritten; room is always set when empty
  assign slot     = room ? held_r[IDX_W-1:0] : held_dec[IDX_W-1:0];

  assign add_go  = sel_go & (cmd_r == CMD_ADD);
  assign swap_go = sel_go & (cmd_r == CMD_LOOKUP) & hit;

  always_comb begin
    held_nxt = held_r;
    if (add_go && room) begin
      held_nxt = held_r + CNT_W'(1);
    end
  end

  // first matching held position: lowest set bit of the qualified match vector
  assign match_ok  = match_raw & valid_pos;
  assign first_hit = match_ok & (~match_ok + CACHE_DEPTH'(1));
  assign hit       = |match_ok;

  // one-hot readout of the hit entry
  always_comb begin
    hit_word = '0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      hit_word = hit_word | (words[i] & {$bits(entry_t){first_hit[i]}});
    end
  end

  // the row of cells
  genvar g;
  generate
    for (g = 0; g < CACHE_DEPTH; g++) begin : g_cell
      cell_ctl_t ctl;
      entry_t    left_w;
      entry_t    right_w;

      assign valid_pos[g] = held_r > CNT_W'(g);

      if (g == 0) begin : g_front
        assign left_w         = words[g];
        assign ctl.take_left  = 1'b0;
      end else begin : g_mid_l
        assign left_w         = words[g-1];
        // hit here moves one place toward the front
        assign ctl.take_left  = swap_go & first_hit[g];
      end

      if (g == CACHE_DEPTH - 1) begin : g_tail
        assign right_w        = words[g];
        assign ctl.take_right = 1'b0;
      end else begin : g_mid_r
        assign right_w        = words[g+1];
        // entry behind us was hit: step back to make room
        assign ctl.take_right = swap_go & first_hit[g+1];
      end

      assign ctl.cmp_en   = cmp_r;
      assign ctl.load_new = add_go & (slot == IDX_W'(g));

      tcc_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .key        (item_r.tag_index),
        .new_word   (item_r),
        .left_word  (left_w),
        .right_word (right_w),
        .word       (words[g]),
        .match      (match_raw[g])
      );
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (sel_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_r       <= 1'b0;
      sel_r       <= 1'b0;
      held_r      <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cmp_r       <= cmp_nxt;
      sel_r       <= sel_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_cache_limit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r            <= in_command;
      item_r.tag_index <= in_tag_index;
      item_r.tag_type  <= in_tag_type;
      item_r.tag_count <= in_tag_count;
    end
    if (sel_go) begin
      if (cmd_r == CMD_ADD) begin
        status_r <= STATUS_OK;
        type_r   <= '0;
        count_r  <= '0;
      end else if (hit) begin
        status_r <= STATUS_OK;
        type_r   <= hit_word.tag_type;
        count_r  <= hit_word.tag_count;
      end else begin
        status_r <= STATUS_MISS;
        type_r   <= '0;
        count_r  <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_type  = type_r;
  assign out_found_count = count_r;

`ifndef SYNTH
  // a word never sits in both pipeline cycles at once
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmp_r && sel_r))
    else $error("compare and select active together");

  // at most one position is picked as the first hit
  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_hit))
    else $error("more than one first hit");

  // held count stays within the row
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(CACHE_DEPTH))
    else $error("held count beyond depth");

  // a finished select always produces a result word
  a_sel_result: assert property (@(posedge clk) disable iff (!rst_n)
    sel_go |=> out_valid_r)
    else $error("select finished without result");

  // compare cycle always hands over to the select cycle
  a_cmp_to_sel: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_r |=> sel_r)
    else $error("compare not followed by select");
`endif

endmodule

@@ hw/rtl/tcc_cell.sv @@
// one list position: holds an entry, compares it and swaps with neighbors
module tcc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcc_pkg::cell_ctl_t            ctl,
  input  logic [tcc_pkg::WORD_W-1:0]    key,
  input  tcc_pkg::entry_t               new_word,
  input  tcc_pkg::entry_t               left_word,
  input  tcc_pkg::entry_t               right_word,
  output tcc_pkg::entry_t               word,
  output logic                          match
);
  import tcc_pkg::*;

  entry_t word_r;
  entry_t word_nxt;
  logic   match_r;

  always_comb begin
    word_nxt = word_r;
    if (ctl.load_new) begin
      word_nxt = new_word;
    end else if (ctl.take_left) begin
      word_nxt = left_word;
    end else if (ctl.take_right) begin
      word_nxt = right_word;
    end
  end

  // entry data carries no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      match_r <= (word_r.tag_index == key);
    end
  end

  assign word  = word_r;
  assign match = match_r;

endmodule

@@ tb/sv/tcc_checker.sv @@
`timescale 1ns / 1ps
// checker for the transpose tag cache: mirrors the entry list and compares every result word
module tcc_checker #(
  parameter int unsigned CACHE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_command,
  input  logic [tcc_pkg::WORD_W-1:0]  in_tag_index,
  input  logic [tcc_pkg::WORD_W-1:0]  in_tag_type,
  input  logic [tcc_pkg::WORD_W-1:0]  in_tag_count,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_status,
  input  logic [tcc_pkg::WORD_W-1:0]  out_found_type,
  input  logic [tcc_pkg::WORD_W-1:0]  out_found_count,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tcc_pkg::LIMIT_W-1:0] cfg_cache_limit,
  output int                          mismatches,
  output int                          results_due
);

  typedef struct packed {
    logic                       status;
    logic [tcc_pkg::WORD_W-1:0] found_type;
    logic [tcc_pkg::WORD_W-1:0] found_count;
  } result_word_t;

  tcc_pkg::entry_t              entry_row [CACHE_DEPTH];
  int                           entries_held;
  logic [tcc_pkg::LIMIT_W-1:0]  held_limit;
  result_word_t                 results_awaited [$];
  int                           errors = 0;

  assign mismatches = errors;

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endfunction

  // one word through the cache: append/overwrite on add, search and transpose on lookup
  function automatic result_word_t cache_apply(input logic cmd,
                                               input logic [tcc_pkg::WORD_W-1:0] idx,
                                               input logic [tcc_pkg::WORD_W-1:0] typ,
                                               input logic [tcc_pkg::WORD_W-1:0] cnt);
    int              room;
    int              hit_pos;
    tcc_pkg::entry_t moved;
    result_word_t    res;
    res = '0;
    res.status = tcc_pkg::STATUS_OK;
    room = (held_limit > CACHE_DEPTH) ? CACHE_DEPTH : int'(held_limit);
    if (room < 1) room = 1;
    if (cmd == tcc_pkg::CMD_ADD) begin
      if (entries_held < room) begin
        entry_row[entries_held] = {idx, typ, cnt};
        entries_held++;
      end else begin
        entry_row[entries_held-1] = {idx, typ, cnt};
      end
    end else begin
      hit_pos = -1;
      // scan from the tail so the frontmost match wins
      for (int p = entries_held - 1; p >= 0; p--)
        if (entry_row[p].tag_index == idx) hit_pos = p;
      if (hit_pos < 0) begin
        res.status = tcc_pkg::STATUS_MISS;
      end else begin
        res.found_type  = entry_row[hit_pos].tag_type;
        res.found_count = entry_row[hit_pos].tag_count;
        if (hit_pos > 0) begin
          moved                = entry_row[hit_pos];
          entry_row[hit_pos]   = entry_row[hit_pos-1];
          entry_row[hit_pos-1] = moved;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_word_t want;
    if (!rst_n) begin
      entries_held = 0;
      held_limit   = tcc_pkg::LIMIT_RESET;
      results_awaited.delete();
      results_due <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_awaited.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, got %b/%h/%h",
                   $time, out_status, out_found_type, out_found_count);
          errors++;
        end else begin
          want = results_awaited.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("found_type", want.found_type, out_found_type);
          check_field("found_count", want.found_count, out_found_count);
        end
      end
      if (cfg_valid && cfg_ready) held_limit = cfg_cache_limit;
      if (in_valid && !in_stall)
        results_awaited.push_back(cache_apply(in_command, in_tag_index, in_tag_type,
                                              in_tag_count));
      results_due <= results_awaited.size();
    end
  end

endmodule

@@ tb/sv/transpose_tag_cache_test.sv @@
`timescale 1ns / 1ps
// top of the transpose tag cache test: clock, reset, stimulus, idling and verdict
module transpose_tag_cache_test;

  localparam int unsigned DEPTH       = 64;
  localparam int          CYCLE_LIMIT = 400000;  // far above the slowest legal run
  localparam int          POOL_SIZE   = 24;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        in_command;
  logic [tcc_pkg::WORD_W-1:0]  in_tag_index;
  logic [tcc_pkg::WORD_W-1:0]  in_tag_type;
  logic [tcc_pkg::WORD_W-1:0]  in_tag_count;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_status;
  logic [tcc_pkg::WORD_W-1:0]  out_found_type;
  logic [tcc_pkg::WORD_W-1:0]  out_found_count;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [tcc_pkg::LIMIT_W-1:0] cfg_cache_limit;

  int                          fail_total;
  int                          words_in_flight;
  int                          cycle_count = 0;
  int                          gap_odds = 0;     // one word in this many follows a gap, 0 = none
  bit                          stall_quiet = 1'b1;
  int                          stall_left = 0;
  logic [tcc_pkg::WORD_W-1:0]  key_pool [POOL_SIZE];

  transpose_tag_cache #(.CACHE_DEPTH(DEPTH)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_tag_index    (in_tag_index),
    .in_tag_type     (in_tag_type),
    .in_tag_count    (in_tag_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_type  (out_found_type),
    .out_found_count (out_found_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_cache_limit (cfg_cache_limit)
  );

  // watches all three channels, keeps its own copy of the list and scores the results
  tcc_checker #(.CACHE_DEPTH(DEPTH)) results_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_tag_index    (in_tag_index),
    .in_tag_type     (in_tag_type),
    .in_tag_count    (in_tag_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_type  (out_found_type),
    .out_found_count (out_found_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_cache_limit (cfg_cache_limit),
    .mismatches      (fail_total),
    .results_due     (words_in_flight)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side back-pressure: random bursts of stalled cycles unless told to stay quiet
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!stall_quiet && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // present one request word, optionally after a short gap, and hold it until taken
  task automatic send_word(input logic cmd, input logic [tcc_pkg::WORD_W-1:0] idx,
                           input logic [tcc_pkg::WORD_W-1:0] typ,
                           input logic [tcc_pkg::WORD_W-1:0] cnt);
    int gap;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_tag_index <= idx;
    in_tag_type  <= typ;
    in_tag_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait until every result word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    // give the select stage extra room before returning
    repeat (4) @(posedge clk);
  endtask

  // the limit only changes while the cache is idle
  task automatic write_limit(input logic [tcc_pkg::LIMIT_W-1:0] value);
    drain_results();
    cfg_valid       <= 1'b1;
    cfg_cache_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one random phase: fresh key pool, mostly pool hits with some misses and adds
  task automatic run_phase(input logic [tcc_pkg::LIMIT_W-1:0] lim, input int words,
                           input int gaps, input bit quiet);
    logic [tcc_pkg::WORD_W-1:0] key;
    bit                         add;
    write_limit(lim);
    gap_odds    = gaps;
    stall_quiet = quiet;
    foreach (key_pool[k]) begin
      if ($urandom_range(0, 7) == 0)
        key_pool[k] = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      else
        key_pool[k] = $urandom();
    end
    repeat (words) begin
      add = ($urandom_range(0, 9) < 3);
      // lookups of unknown keys give the miss path
      if (add || $urandom_range(0, 4) != 0)
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        key = $urandom();
      send_word(add ? tcc_pkg::CMD_ADD : tcc_pkg::CMD_LOOKUP, key, $urandom(), $urandom());
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_command      <= tcc_pkg::CMD_LOOKUP;
    in_tag_index    <= '0;
    in_tag_type     <= '0;
    in_tag_count    <= '0;
    cfg_valid       <= 1'b0;
    cfg_cache_limit <= '0;
    out_stall       <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: limit zero on an empty cache, first add must still land at the front
    write_limit(7'd0);
    send_word(tcc_pkg::CMD_LOOKUP, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // empty, miss
    send_word(tcc_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_word(tcc_pkg::CMD_ADD, 32'h0, 32'hFFFF_FFFF, 32'h0);  // overwrites the only entry
    send_word(tcc_pkg::CMD_LOOKUP, 32'h0, 32'h0, 32'h0);        // hit at front
    send_word(tcc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);  // gone, miss

    // directed: grow the list, duplicate index, walk a tag to the front
    write_limit(7'd64);
    send_word(tcc_pkg::CMD_ADD, 32'hA5A5_A5A5, 32'h1, 32'h2);
    send_word(tcc_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h3, 32'h4);
    send_word(tcc_pkg::CMD_ADD, 32'h0, 32'h5, 32'h6);  // second entry with index 0
    send_word(tcc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_word(tcc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_word(tcc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);  // now at front
    send_word(tcc_pkg::CMD_LOOKUP, 32'h0, 32'h0, 32'h0);  // frontmost index 0 wins
    send_word(tcc_pkg::CMD_LOOKUP, 32'h5A5A_5A5A, 32'h0, 32'h0);  // miss

    // directed: limit below the held count, adds keep hitting the tail
    write_limit(7'd2);
    send_word(tcc_pkg::CMD_ADD, 32'h1234_5678, 32'h7, 32'h8);
    send_word(tcc_pkg::CMD_ADD, 32'h8765_4321, 32'h9, 32'hA);
    send_word(tcc_pkg::CMD_LOOKUP, 32'h1234_5678, 32'h0, 32'h0);  // overwritten, miss
    send_word(tcc_pkg::CMD_LOOKUP, 32'h8765_4321, 32'h0, 32'h0);  // tail hit, swaps

    // directed: limit above the depth saturates
    write_limit(7'd127);
    send_word(tcc_pkg::CMD_ADD, 32'hDEAD_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(tcc_pkg::CMD_LOOKUP, 32'hDEAD_0001, 32'h0, 32'h0);

    // random phases across a spread of limits, some with no idling at all
    run_phase(7'd5, 250, 4, 1'b0);
    run_phase(7'd12, 250, 0, 1'b1);
    run_phase(7'd40, 250, 3, 1'b0);
    run_phase(7'd64, 250, 6, 1'b0);
    run_phase(7'd127, 250, 2, 1'b0);
    run_phase(7'd1, 250, 5, 1'b1);
    run_phase(7'($urandom_range(0, 127)), 250, 4, 1'b0);
    // closing stretch runs flat out on both sides
    run_phase(7'd90, 200, 0, 1'b1);

    drain_results();
    if (fail_total == 0 && words_in_flight == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
